/* rtl/tclb_pkg.sv */
// Package for the text console line buffer: sizes, character codes,
// word types, controller states and the memory request bundle.
// Used by every file under rtl except tclb_ram.
package tclb_pkg;

  localparam int LINES     = 32;
  localparam int WIDTH     = 64;
  localparam int LINE_W    = $clog2(LINES);
  localparam int COL_W     = $clog2(WIDTH);
  localparam int CUR_COL_W = $clog2(WIDTH + 1);
  localparam int USED_W    = $clog2(LINES + 1);
  localparam int ADDR_W    = LINE_W + COL_W;
  localparam int CHAR_W    = 8;

  localparam logic [CHAR_W-1:0] CH_NUL = 8'd0;
  localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;

  localparam logic FUNC_APPEND = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  typedef struct packed {
    logic              func;
    logic [CHAR_W-1:0] char_code;
    logic [4:0]        read_line;
    logic [5:0]        read_column;
  } req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] read_char;
    logic [4:0]        cursor_row;
    logic [6:0]        cursor_col;
    logic [5:0]        lines_used;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_PUT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

/* rtl/tclb_ram.sv */
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module tclb_ram #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/tclb_ctrl.sv */
// Cursor controller: decodes each word, drives the cell RAM, sweeps new
// lines clear and scans for a line's end. Depends on tclb_pkg.
module tclb_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  tclb_pkg::req_t            req,
  output logic                      res_valid,
  input  logic                      res_ready,
  output tclb_pkg::rsp_t            res,
  output tclb_pkg::mem_req_t        mem,
  input  logic [tclb_pkg::CHAR_W-1:0] rdata
);

  tclb_pkg::state_t state, state_next;

  logic [tclb_pkg::LINE_W-1:0]    cur_line;
  logic [tclb_pkg::CUR_COL_W-1:0] cur_col;
  logic [tclb_pkg::USED_W-1:0]    used;
  logic [tclb_pkg::LINES-1:0]     row_valid;
  logic [tclb_pkg::COL_W-1:0]     cnt;
  logic [tclb_pkg::COL_W-1:0]     scan_idx;
  logic [tclb_pkg::CHAR_W-1:0]    pend_char;
  logic                           pend_put;
  logic                           booting;
  logic [tclb_pkg::CHAR_W-1:0]    res_char;
  logic                           rd_mask;

  logic                           acc, is_read, is_nl, is_bs, is_nul;
  logic                           col_zero, col_full;
  logic [tclb_pkg::LINE_W-1:0]    line_inc, tgt_line;
  logic [tclb_pkg::USED_W-1:0]    used_inc, used_dec;
  logic [tclb_pkg::COL_W-1:0]     col_lo, col_dec;
  logic                           sweep_last, scan_hit, scan_last;

  assign acc      = req_valid && req_ready;
  assign is_read  = (req.func == tclb_pkg::FUNC_READ);
  assign is_nl    = (req.char_code == tclb_pkg::CH_NL);
  assign is_bs    = (req.char_code == tclb_pkg::CH_BS);
  assign is_nul   = (req.char_code == tclb_pkg::CH_NUL);
  assign col_zero = (cur_col == '0);
  assign col_full = (cur_col == tclb_pkg::CUR_COL_W'(tclb_pkg::WIDTH));
  assign col_lo   = cur_col[tclb_pkg::COL_W-1:0];
  assign col_dec  = col_lo - 1'b1;

  // ring step forward, saturating line count
  assign line_inc = (cur_line == tclb_pkg::LINE_W'(tclb_pkg::LINES - 1)) ? '0
                  : cur_line + 1'b1;
  assign used_inc = (used == tclb_pkg::USED_W'(tclb_pkg::LINES)) ? used : used + 1'b1;
  assign used_dec = (used == '0) ? used : used - 1'b1;

  // backspace at column 0: up one line, wrap to the last line only if lines are held
  always_comb begin
    if (cur_line != '0) begin
      tgt_line = cur_line - 1'b1;
    end else if (used != '0) begin
      tgt_line = tclb_pkg::LINE_W'(tclb_pkg::LINES - 1);
    end else begin
      tgt_line = cur_line;
    end
  end

  assign sweep_last = (cnt == tclb_pkg::COL_W'(tclb_pkg::WIDTH - 1));
  assign scan_hit   = (rdata == tclb_pkg::CH_NUL);
  assign scan_last  = (scan_idx == tclb_pkg::COL_W'(tclb_pkg::WIDTH - 1));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tclb_pkg::ST_IDLE: begin
        if (acc) begin
          if (is_read) begin
            state_next = tclb_pkg::ST_READ;
          end else if (is_nl) begin
            state_next = tclb_pkg::ST_SWEEP;
          end else if (is_bs) begin
            if (!col_zero) begin
              state_next = tclb_pkg::ST_DONE;
            end else if (row_valid[tgt_line]) begin
              state_next = tclb_pkg::ST_SCAN;
            end else begin
              state_next = tclb_pkg::ST_SWEEP;
            end
          end else if (is_nul) begin
            state_next = tclb_pkg::ST_DONE;
          end else if (col_full) begin
            state_next = tclb_pkg::ST_SWEEP;
          end else begin
            state_next = tclb_pkg::ST_DONE;
          end
        end
      end
      tclb_pkg::ST_READ: state_next = tclb_pkg::ST_DONE;
      tclb_pkg::ST_SWEEP: begin
        if (sweep_last) begin
          if (booting) begin
            state_next = tclb_pkg::ST_IDLE;
          end else if (pend_put) begin
            state_next = tclb_pkg::ST_PUT;
          end else begin
            state_next = tclb_pkg::ST_DONE;
          end
        end
      end
      tclb_pkg::ST_PUT: state_next = tclb_pkg::ST_DONE;
      tclb_pkg::ST_SCAN: begin
        if (scan_hit || scan_last) begin
          state_next = tclb_pkg::ST_DONE;
        end
      end
      tclb_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = tclb_pkg::ST_IDLE;
        end
      end
      default: state_next = tclb_pkg::ST_IDLE;
    endcase
  end

  // outputs and RAM requests
  always_comb begin
    req_ready = 1'b0;
    res_valid = 1'b0;
    mem.we    = 1'b0;
    mem.waddr = {cur_line, cnt};
    mem.wdata = tclb_pkg::CH_NUL;
    mem.raddr = {cur_line, scan_idx + 1'b1};
    unique case (state)
      tclb_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        mem.raddr = is_read ? {req.read_line, req.read_column} : {tgt_line, {tclb_pkg::COL_W{1'b0}}};
        if (acc && !is_read) begin
          if (is_nl) begin
            mem.we    = !col_full;
            mem.waddr = {cur_line, col_lo};
          end else if (is_bs) begin
            mem.we    = !col_zero;
            mem.waddr = {cur_line, col_dec};
          end else if (!is_nul) begin
            mem.we    = !col_full;
            mem.waddr = {cur_line, col_lo};
            mem.wdata = req.char_code;
          end
        end
      end
      tclb_pkg::ST_SWEEP: mem.we = 1'b1;
      tclb_pkg::ST_PUT: begin
        mem.we    = 1'b1;
        mem.waddr = {cur_line, {tclb_pkg::COL_W{1'b0}}};
        mem.wdata = pend_char;
      end
      tclb_pkg::ST_DONE: res_valid = 1'b1;
      default: ;
    endcase
  end

  assign res.read_char  = res_char;
  assign res.cursor_row = cur_line;
  assign res.cursor_col = cur_col;
  assign res.lines_used = used;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tclb_pkg::ST_SWEEP;
      booting   <= 1'b1;
      cur_line  <= '0;
      cur_col   <= '0;
      used      <= '0;
      row_valid <= '0;
      cnt       <= '0;
      pend_put  <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        tclb_pkg::ST_IDLE: begin
          if (acc && !is_read) begin
            if (is_nl) begin
              cur_line <= line_inc;
              cur_col  <= '0;
              used     <= used_inc;
              cnt      <= '0;
              pend_put <= 1'b0;
            end else if (is_bs) begin
              if (!col_zero) begin
                cur_col <= cur_col - 1'b1;
              end else begin
                cur_line <= tgt_line;
                used     <= used_dec;
                cnt      <= '0;
                pend_put <= 1'b0;
              end
            end else if (!is_nul) begin
              if (col_full) begin
                cur_line <= line_inc;
                cur_col  <= '0;
                used     <= used_inc;
                cnt      <= '0;
                pend_put <= 1'b1;
              end else begin
                cur_col <= cur_col + 1'b1;
              end
            end
          end
        end
        tclb_pkg::ST_SWEEP: begin
          cnt <= cnt + 1'b1;
          if (sweep_last) begin
            row_valid[cur_line] <= 1'b1;
            booting             <= 1'b0;
          end
        end
        tclb_pkg::ST_PUT: cur_col <= tclb_pkg::CUR_COL_W'(1);
        tclb_pkg::ST_SCAN: begin
          if (scan_hit) begin
            cur_col <= {1'b0, scan_idx};
          end else if (scan_last) begin
            cur_col <= tclb_pkg::CUR_COL_W'(tclb_pkg::WIDTH);
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == tclb_pkg::ST_IDLE && acc) begin
      res_char  <= tclb_pkg::CH_NUL;
      rd_mask   <= row_valid[req.read_line];
      pend_char <= req.char_code;
      scan_idx  <= '0;
    end else if (state == tclb_pkg::ST_READ) begin
      res_char <= rd_mask ? rdata : tclb_pkg::CH_NUL;
    end else if (state == tclb_pkg::ST_SCAN) begin
      scan_idx <= scan_idx + 1'b1;
    end
  end

endmodule

/* rtl/text_console_line_buffer.sv */
// Flow: a plain character, a null or a backspace inside a line goes from
// idle straight to done; a read passes through the read state first. A
// newline or line wrap sweeps the new line clear (a wrap then stores the
// char). Backspace to the line above scans for the first empty cell, or
// clears a line never entered. A new word is taken only once the last one
// has left the controller; a line clear writes all 64 cells through the
// single RAM write port. Reset: synchronous; line 0 is cleared first, during which req_ready stays low.
module text_console_line_buffer (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  tclb_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output tclb_pkg::rsp_t  rsp
);

  // Controller to output stage
  logic                        res_valid;
  logic                        res_ready;
  tclb_pkg::rsp_t              res;

  // Controller to cell RAM
  tclb_pkg::mem_req_t          mem;
  logic [tclb_pkg::CHAR_W-1:0] rdata;

  tclb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem       (mem),
    .rdata     (rdata)
  );

  // Cell store: LINES x WIDTH characters, line in the upper address bits.
  // Rows never entered since reset are masked to zero by per-row valid bits
  // in the controller and cleared on first entry.
  tclb_ram #(
    .ADDR_W (tclb_pkg::ADDR_W),
    .DATA_W (tclb_pkg::CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem.we),
    .waddr (mem.waddr),
    .wdata (mem.wdata),
    .raddr (mem.raddr),
    .rdata (rdata)
  );

  // Output register: the controller drops back to idle as soon as the word
  // lands here, so the next request is taken while this one waits.
  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

/* rtl/tclb_chk.sv */
// Port-level checker for the text console line buffer, bound to the top.
// Depends on tclb_pkg.
module tclb_chk (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tclb_pkg::rsp_t rsp
);

  // no word leaves straight out of reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("rsp_valid high after reset");

  // a stalled result word holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled rsp changed");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.lines_used <= 6'(tclb_pkg::LINES))
    else $error("lines_used above LINES");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.cursor_col <= 7'(tclb_pkg::WIDTH))
    else $error("cursor_col above WIDTH");

  // no request is taken in the cycle straight after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("back-to-back accept");

endmodule

bind text_console_line_buffer tclb_chk u_tclb_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
